>>> rtl/core/tilt_and_heading_calc_macros.svh
// Assertion macros shared by the tilt and heading calculator.
`ifndef TILT_AND_HEADING_CALC_MACROS_SVH
`define TILT_AND_HEADING_CALC_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TAC_CHECK(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TAC_CHECK_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/core/tac_pkg.sv
// Shared types, constants and angle table for the tilt and heading calculator.
`default_nettype none
package tac_pkg;
   localparam int ANGLE_FRACTION_BITS_DEF = 16;
   localparam int TABLE_BITS = 24;
   localparam int TABLE_LEN  = 26;
   localparam int DATA_W  = 36;
   localparam int SUM_W   = 32;
   localparam int ROOT_W  = 32;
   localparam int ANGLE_W = 9;
   localparam int RAD_W   = 30;
   localparam logic [RAD_W-1:0] RAD_FIX_Q30 = 30'd1073602618;
   localparam int ROLL_LIMIT    = 90;
   localparam int HEADING_LIMIT = 180;

   localparam logic CSR_MAG_ADJUST_X = 1'b0;
   localparam logic CSR_MAG_ADJUST_Y = 1'b1;

   localparam logic [31:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
      32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
      32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
      32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
      32'd115, 32'd57, 32'd29
   };

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] num;
      logic signed [DATA_W-1:0] den;
   } tac_vec_type;

   // atan(2^-idx) in degrees, rounded half up to frac fraction bits
   function automatic logic [31:0] atan_step(input int idx, input int frac);
      int          sh;
      logic [31:0] t;
      sh = TABLE_BITS - frac;
      t  = ATAN_DEG_Q24[idx];
      if (sh == 0) begin
         return t;
      end
      return (t + (32'd1 << (sh - 1))) >> sh;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/tac_sqrt.sv
// Pipelined integer square root of (sum << 32), one root bit per stage.
`default_nettype none
module tac_sqrt (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire logic [tac_pkg::SUM_W-1:0]        in_sum,
   input  wire logic signed [tac_pkg::DATA_W-1:0] in_num,
   output tac_pkg::tac_vec_type                  out_vec
);
   localparam int RW = tac_pkg::ROOT_W;
   localparam int REM_W = RW + 3;

   logic                              valid_ff [RW];
   logic [REM_W-1:0]                  rem_ff   [RW];
   logic [RW-1:0]                     root_ff  [RW];
   logic [tac_pkg::SUM_W-1:0]         bits_ff  [RW];
   logic signed [tac_pkg::DATA_W-1:0] num_ff   [RW];

   genvar k;
   generate
      for (k = 0; k < RW; k++) begin : g_stage
         logic                              src_valid;
         logic [REM_W-1:0]                  src_rem;
         logic [RW-1:0]                     src_root;
         logic [tac_pkg::SUM_W-1:0]         src_bits;
         logic signed [tac_pkg::DATA_W-1:0] src_num;
         logic [REM_W-1:0]                  rem_raw;
         logic [REM_W-1:0]                  trial;
         logic                              take;
         logic [REM_W-1:0]                  rem_in;
         logic [RW-1:0]                     root_in;

         if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_bits  = in_sum;
            assign src_num   = in_num;
         end else begin : g_next
            assign src_valid = valid_ff[k-1];
            assign src_rem   = rem_ff[k-1];
            assign src_root  = root_ff[k-1];
            assign src_bits  = bits_ff[k-1];
            assign src_num   = num_ff[k-1];
         end

         // bring down two bits, try (root << 2) | 1
         always_comb begin
            rem_raw = {src_rem[REM_W-3:0], src_bits[tac_pkg::SUM_W-1 -: 2]};
            trial   = {1'b0, src_root, 2'b01};
            take    = (rem_raw >= trial);
            rem_in  = take ? (rem_raw - trial) : rem_raw;
            root_in = {src_root[RW-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= src_valid;
            end
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            bits_ff[k] <= src_bits << 2;
            num_ff[k]  <= src_num;
         end
      end
   endgenerate

   assign out_vec.valid = valid_ff[RW-1];
   assign out_vec.num   = num_ff[RW-1];
   assign out_vec.den   = $signed({{(tac_pkg::DATA_W - RW){1'b0}}, root_ff[RW-1]});
endmodule
`default_nettype wire

>>> rtl/core/tac_cordic.sv
// Pipelined vectoring CORDIC atan2 with degree scaling, truncation and clamping.
`default_nettype none
module tac_cordic #(
   parameter int FRAC  = tac_pkg::ANGLE_FRACTION_BITS_DEF,
   parameter int LIMIT = tac_pkg::ROLL_LIMIT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tac_pkg::tac_vec_type              in_vec,
   output logic                                   out_valid,
   output logic signed [tac_pkg::ANGLE_W-1:0]     out_angle
);
   localparam int DW    = tac_pkg::DATA_W;
   localparam int ZW    = FRAC + 10;
   localparam int ITERS = FRAC + 2;
   localparam int PW    = ZW + tac_pkg::RAD_W;
   localparam int MW    = PW - (tac_pkg::RAD_W + FRAC);
   localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180) <<< FRAC;

   // prep stage
   logic                 p_valid_ff, p_zero_ff;
   logic signed [DW-1:0] p_n_ff, p_d_ff;
   logic signed [ZW-1:0] p_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_vec.valid;
      end
      p_zero_ff <= (in_vec.num == '0) && (in_vec.den == '0);
      if (in_vec.den < 0) begin
         p_z_ff <= (in_vec.num < 0) ? -HALF_TURN : HALF_TURN;
         p_n_ff <= -in_vec.num;
         p_d_ff <= -in_vec.den;
      end else begin
         p_z_ff <= '0;
         p_n_ff <= in_vec.num;
         p_d_ff <= in_vec.den;
      end
   end

   logic                 it_valid_ff [ITERS];
   logic                 it_zero_ff  [ITERS];
   logic signed [DW-1:0] it_n_ff     [ITERS];
   logic signed [DW-1:0] it_d_ff     [ITERS];
   logic signed [ZW-1:0] it_z_ff     [ITERS];

   genvar i;
   generate
      for (i = 0; i < ITERS; i++) begin : g_iter
         localparam logic signed [ZW-1:0] STEP = ZW'(tac_pkg::atan_step(i, FRAC));
         logic                 src_valid, src_zero;
         logic signed [DW-1:0] src_n, src_d;
         logic signed [ZW-1:0] src_z;

         if (i == 0) begin : g_first
            assign src_valid = p_valid_ff;
            assign src_zero  = p_zero_ff;
            assign src_n     = p_n_ff;
            assign src_d     = p_d_ff;
            assign src_z     = p_z_ff;
         end else begin : g_next
            assign src_valid = it_valid_ff[i-1];
            assign src_zero  = it_zero_ff[i-1];
            assign src_n     = it_n_ff[i-1];
            assign src_d     = it_d_ff[i-1];
            assign src_z     = it_z_ff[i-1];
         end

         // rotate toward the positive real axis
         always_ff @(posedge clock) begin
            if (reset) begin
               it_valid_ff[i] <= 1'b0;
            end else begin
               it_valid_ff[i] <= src_valid;
            end
            it_zero_ff[i] <= src_zero;
            if (!src_n[DW-1]) begin
               it_d_ff[i] <= src_d + (src_n >>> i);
               it_n_ff[i] <= src_n - (src_d >>> i);
               it_z_ff[i] <= src_z + STEP;
            end else begin
               it_d_ff[i] <= src_d - (src_n >>> i);
               it_n_ff[i] <= src_n + (src_d >>> i);
               it_z_ff[i] <= src_z - STEP;
            end
         end
      end
   endgenerate

   // scale by pi/3.142
   logic          m_valid_ff, m_zero_ff, m_neg_ff;
   logic [PW-1:0] m_prod_ff;
   logic [ZW-1:0] z_mag;

   assign z_mag = it_z_ff[ITERS-1][ZW-1] ? ZW'(-it_z_ff[ITERS-1]) : ZW'(it_z_ff[ITERS-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= it_valid_ff[ITERS-1];
      end
      m_zero_ff <= it_zero_ff[ITERS-1];
      m_neg_ff  <= it_z_ff[ITERS-1][ZW-1];
      m_prod_ff <= PW'(z_mag) * PW'(tac_pkg::RAD_FIX_Q30);
   end

   // truncate, clamp, restore sign
   logic [MW-1:0]                      deg;
   logic [tac_pkg::ANGLE_W-1:0]        deg_lim;
   logic signed [tac_pkg::ANGLE_W-1:0] angle_in;
   logic                               o_valid_ff;
   logic signed [tac_pkg::ANGLE_W-1:0] o_angle_ff;

   always_comb begin
      deg      = m_prod_ff[PW-1 -: MW];
      deg_lim  = (deg > MW'(LIMIT)) ? tac_pkg::ANGLE_W'(LIMIT)
                                    : tac_pkg::ANGLE_W'(deg);
      if (m_zero_ff) begin
         angle_in = '0;
      end else if (m_neg_ff) begin
         angle_in = -$signed(deg_lim);
      end else begin
         angle_in = $signed(deg_lim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= m_valid_ff;
      end
      o_angle_ff <= angle_in;
   end

   assign out_valid = o_valid_ff;
   assign out_angle = o_angle_ff;
endmodule
`default_nettype wire

>>> rtl/core/tilt_and_heading_calc.sv
// Top level of the tilt and heading calculator.
// Throughput: one word per cycle; busy stays low, start may be high every cycle.
// A word passes 2 input stages, the 32-stage root pipeline, one prep stage,
//    ANGLE_FRACTION_BITS + 2 CORDIC stages, one scale stage and one output stage.
// Reset (sync, active high) drops words in flight, adjust bytes go to 128; no result stall.
`default_nettype none
module tilt_and_heading_calc #(
   parameter int ANGLE_FRACTION_BITS = tac_pkg::ANGLE_FRACTION_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_accel_x_high,
   input  wire logic [7:0]  req_accel_x_low,
   input  wire logic [7:0]  req_accel_y_high,
   input  wire logic [7:0]  req_accel_y_low,
   input  wire logic [7:0]  req_accel_z_high,
   input  wire logic [7:0]  req_accel_z_low,
   input  wire logic [7:0]  req_mag_x_low,
   input  wire logic [7:0]  req_mag_x_high,
   input  wire logic [7:0]  req_mag_y_low,
   input  wire logic [7:0]  req_mag_y_high,
   output logic             rsp_valid,
   output logic signed [7:0] rsp_roll_degrees,
   output logic signed [7:0] rsp_pitch_degrees,
   output logic signed [8:0] rsp_heading_degrees,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_write_data
);
   localparam int DW      = tac_pkg::DATA_W;
   localparam int RW      = tac_pkg::ROOT_W;
   localparam int LATENCY = ANGLE_FRACTION_BITS + 39;

   // the pipeline never stalls
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // adjustment registers
   logic [7:0] asa_x_ff, asa_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         asa_x_ff <= 8'd128;
         asa_y_ff <= 8'd128;
      end else if (csr_write_en) begin
         case (csr_index)
            tac_pkg::CSR_MAG_ADJUST_X: asa_x_ff <= csr_write_data;
            tac_pkg::CSR_MAG_ADJUST_Y: asa_y_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage 1: unpack words, squares and adjusted magnetometer axes
   logic signed [15:0] ax, ay, az, mx, my;
   logic signed [9:0]  gain_x, gain_y;

   assign ax = $signed({req_accel_x_high, req_accel_x_low});
   assign ay = $signed({req_accel_y_high, req_accel_y_low});
   assign az = $signed({req_accel_z_high, req_accel_z_low});
   assign mx = $signed({req_mag_x_high, req_mag_x_low});
   assign my = $signed({req_mag_y_high, req_mag_y_low});
   assign gain_x = $signed({2'b00, asa_x_ff}) + 10'sd128;
   assign gain_y = $signed({2'b00, asa_y_ff}) + 10'sd128;

   logic               s1_valid_ff;
   logic [30:0]        s1_sq_ax_ff, s1_sq_ay_ff, s1_sq_az_ff;
   logic signed [15:0] s1_ay_ff;
   logic signed [16:0] s1_nax_ff;
   logic signed [25:0] s1_adj_x_ff, s1_adj_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_sq_ax_ff <= 31'(32'(ax) * 32'(ax));
      s1_sq_ay_ff <= 31'(32'(ay) * 32'(ay));
      s1_sq_az_ff <= 31'(32'(az) * 32'(az));
      s1_ay_ff    <= ay;
      s1_nax_ff   <= -(17'(ax));
      s1_adj_x_ff <= 26'(mx) * 26'(gain_x);
      s1_adj_y_ff <= 26'(my) * 26'(gain_y);
   end

   // stage 2: sums of squares and scaled numerators
   logic                      s2_valid_ff;
   logic [tac_pkg::SUM_W-1:0] s2_sum_roll_ff, s2_sum_pitch_ff;
   logic signed [DW-1:0]      s2_num_roll_ff, s2_num_pitch_ff;
   tac_pkg::tac_vec_type      s2_hdg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff     <= 1'b0;
         s2_hdg_ff.valid <= 1'b0;
      end else begin
         s2_valid_ff     <= s1_valid_ff;
         s2_hdg_ff.valid <= s1_valid_ff;
      end
      s2_sum_roll_ff  <= tac_pkg::SUM_W'(s1_sq_ax_ff) + tac_pkg::SUM_W'(s1_sq_az_ff);
      s2_sum_pitch_ff <= tac_pkg::SUM_W'(s1_sq_ay_ff) + tac_pkg::SUM_W'(s1_sq_az_ff);
      s2_num_roll_ff  <= DW'(s1_ay_ff) <<< 16;
      s2_num_pitch_ff <= DW'(s1_nax_ff) <<< 16;
      s2_hdg_ff.num   <= DW'(s1_adj_x_ff) <<< 8;
      s2_hdg_ff.den   <= DW'(s1_adj_y_ff) <<< 8;
   end

   // roots for roll and pitch denominators
   tac_pkg::tac_vec_type roll_vec, pitch_vec;

   tac_sqrt u_sqrt_roll (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_sum   (s2_sum_roll_ff),
      .in_num   (s2_num_roll_ff),
      .out_vec  (roll_vec)
   );

   tac_sqrt u_sqrt_pitch (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid_ff),
      .in_sum   (s2_sum_pitch_ff),
      .in_num   (s2_num_pitch_ff),
      .out_vec  (pitch_vec)
   );

   // hold the heading vector alongside the root pipeline
   tac_pkg::tac_vec_type hdg_dly_ff [RW];

   genvar k;
   generate
      for (k = 0; k < RW; k++) begin : g_hdg_dly
         tac_pkg::tac_vec_type src;
         if (k == 0) begin : g_first
            assign src = s2_hdg_ff;
         end else begin : g_next
            assign src = hdg_dly_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               hdg_dly_ff[k].valid <= 1'b0;
            end else begin
               hdg_dly_ff[k].valid <= src.valid;
            end
            hdg_dly_ff[k].num <= src.num;
            hdg_dly_ff[k].den <= src.den;
         end
      end
   endgenerate

   // three CORDIC lanes run in lockstep
   logic                               roll_valid, pitch_valid, hdg_valid;
   logic signed [tac_pkg::ANGLE_W-1:0] roll_deg, pitch_angle, hdg_angle;

   tac_cordic #(.FRAC(ANGLE_FRACTION_BITS), .LIMIT(tac_pkg::ROLL_LIMIT)) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .in_vec    (roll_vec),
      .out_valid (roll_valid),
      .out_angle (roll_deg)
   );

   tac_cordic #(.FRAC(ANGLE_FRACTION_BITS), .LIMIT(tac_pkg::ROLL_LIMIT)) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_vec    (pitch_vec),
      .out_valid (pitch_valid),
      .out_angle (pitch_angle)
   );

   tac_cordic #(.FRAC(ANGLE_FRACTION_BITS), .LIMIT(tac_pkg::HEADING_LIMIT)) u_cordic_hdg (
      .clock     (clock),
      .reset     (reset),
      .in_vec    (hdg_dly_ff[RW-1]),
      .out_valid (hdg_valid),
      .out_angle (hdg_angle)
   );

   assign rsp_valid           = roll_valid;
   assign rsp_roll_degrees    = roll_deg[7:0];
   assign rsp_pitch_degrees   = pitch_angle[7:0];
   assign rsp_heading_degrees = hdg_angle;

`include "tilt_and_heading_calc_macros.svh"

   // lanes stay aligned
   `TAC_CHECK(a_lanes_aligned, roll_valid, pitch_valid && hdg_valid, "lanes out of step")
   // every result word traces back to an accepted start
   `TAC_CHECK(a_result_has_req, rsp_valid, $past(accept, LATENCY), "result without request")
   // an all-zero accel sample gives zero roll and pitch
   `TAC_CHECK(a_zero_tilt, rsp_valid && $past(accept && ax == 16'sd0 && ay == 16'sd0 && az == 16'sd0, LATENCY), rsp_roll_degrees == 8'sd0 && rsp_pitch_degrees == 8'sd0, "zero vector not zero")
   // a write to adjust X lands next cycle
   `TAC_CHECK_NEXT(a_csr_x, csr_write_en && csr_index == tac_pkg::CSR_MAG_ADJUST_X, asa_x_ff == $past(csr_write_data), "adjust X write lost")
endmodule
`default_nettype wire

>>> tb/tb_tilt_and_heading_calc.sv
// Self-checking testbench for the tilt and heading calculator.
`timescale 1ns / 1ps
`default_nettype none
module tb_tilt_and_heading_calc;
   localparam int FRAC_BITS = 16;
   localparam int LATENCY   = FRAC_BITS + 39;

   // One sensor word: ten raw bytes in port order.
   typedef struct packed {
      logic [7:0] ax_h, ax_l, ay_h, ay_l, az_h, az_l;
      logic [7:0] mx_l, mx_h, my_l, my_h;
   } sensor_word_type;

   typedef struct packed {
      logic signed [7:0] roll;
      logic signed [7:0] pitch;
      logic signed [8:0] heading;
   } angle_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_accel_x_high = '0, req_accel_x_low = '0;
   logic [7:0] req_accel_y_high = '0, req_accel_y_low = '0;
   logic [7:0] req_accel_z_high = '0, req_accel_z_low = '0;
   logic [7:0] req_mag_x_low = '0, req_mag_x_high = '0;
   logic [7:0] req_mag_y_low = '0, req_mag_y_high = '0;
   logic rsp_valid;
   logic signed [7:0] rsp_roll_degrees, rsp_pitch_degrees;
   logic signed [8:0] rsp_heading_degrees;
   logic       csr_write_en = 1'b0;
   logic       csr_index = tac_pkg::CSR_MAG_ADJUST_X;
   logic [7:0] csr_write_data = '0;

   tilt_and_heading_calc u_dut (
      .clock, .reset, .start, .busy,
      .req_accel_x_high, .req_accel_x_low, .req_accel_y_high, .req_accel_y_low,
      .req_accel_z_high, .req_accel_z_low, .req_mag_x_low, .req_mag_x_high,
      .req_mag_y_low, .req_mag_y_high,
      .rsp_valid, .rsp_roll_degrees, .rsp_pitch_degrees, .rsp_heading_degrees,
      .csr_write_en, .csr_index, .csr_write_data
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sensor_word_type pending_words[$];
   angle_word_type  expected_angles[$];
   int   mismatches = 0;
   bit   quiet_tail = 1'b0;   // no idle bursts in the last part of the run
   logic [7:0] adjust_x = 8'd128, adjust_y = 8'd128;

   // ---------------------------------------------------------------------
   // Angle predictor
   // ---------------------------------------------------------------------
   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint vector_length(longint p, longint q);
      longint unsigned s;
      s = longint'(p * p) + longint'(q * q);
      return longint'(int_root(s << 32));
   endfunction

   // Vectoring-mode CORDIC angle, scaled to degrees*pi/3.142, truncated, clamped to lim.
   function automatic longint cordic_degrees(longint n, longint d, longint lim);
      longint z, dd, r, step;
      longint unsigned mag;
      z = 0;
      if (n == 0 && d == 0) return 0;
      // Fold the left half plane over, starting from +-180 degrees.
      if (d < 0) begin
         z = longint'(180) << FRAC_BITS;
         if (n < 0) z = -z;
         d = -d;
         n = -n;
      end
      for (int i = 0; i < FRAC_BITS + 2; i++) begin
         step = longint'((64'(tac_pkg::ATAN_DEG_Q24[i])
                + (64'd1 << (tac_pkg::TABLE_BITS - FRAC_BITS - 1)))
                >> (tac_pkg::TABLE_BITS - FRAC_BITS));
         dd = d;
         if (n >= 0) begin
            d = d + (n >>> i);
            n = n - (dd >>> i);
            z = z + step;
         end else begin
            d = d - (n >>> i);
            n = n + (dd >>> i);
            z = z - step;
         end
      end
      mag = (z < 0) ? longint'(-z) : longint'(z);
      mag = (mag * 64'(tac_pkg::RAD_FIX_Q30)) >> (30 + FRAC_BITS);
      r = longint'(mag);
      if (r > lim) r = lim;
      return (z < 0) ? -r : r;
   endfunction

   function automatic angle_word_type predict_angles(sensor_word_type w);
      longint ax, ay, az, mx, my;
      angle_word_type a;
      ax = longint'($signed({w.ax_h, w.ax_l}));
      ay = longint'($signed({w.ay_h, w.ay_l}));
      az = longint'($signed({w.az_h, w.az_l}));
      mx = longint'($signed({w.mx_h, w.mx_l}));
      my = longint'($signed({w.my_h, w.my_l}));
      a.roll    = 8'(cordic_degrees(ay * 65536, vector_length(ax, az), 90));
      a.pitch   = 8'(cordic_degrees(-ax * 65536, vector_length(ay, az), 90));
      a.heading = 9'(cordic_degrees(mx * (longint'(adjust_x) + 128) * 256,
                                    my * (longint'(adjust_y) + 128) * 256, 180));
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Driver: change inputs on the falling edge, hold start until taken
   // ---------------------------------------------------------------------
   int  idle_left = 0;
   bit  taken = 1'b0;   // word accepted at the last rising edge

   always @(negedge clock) begin
      sensor_word_type w;
      logic next_start;
      next_start = start;
      if (reset) begin
         next_start = 1'b0;
      end else if (!start || taken) begin
         next_start = 1'b0;
         if (idle_left > 0) begin
            idle_left--;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            {req_accel_x_high, req_accel_x_low, req_accel_y_high, req_accel_y_low,
             req_accel_z_high, req_accel_z_low, req_mag_x_low, req_mag_x_high,
             req_mag_y_low, req_mag_y_high} <= w;
            next_start = 1'b1;
            // open an idle burst after this word now and then
            if (!quiet_tail && $urandom_range(0, 5) == 0)
               idle_left = $urandom_range(1, 15);
         end
      end
      start <= next_start;
   end

   // ---------------------------------------------------------------------
   // Monitor: capture accepted words, check each result strobe
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sensor_word_type w;
      angle_word_type  want;
      taken = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            taken = 1'b1;
            w = {req_accel_x_high, req_accel_x_low, req_accel_y_high, req_accel_y_low,
                 req_accel_z_high, req_accel_z_low, req_mag_x_low, req_mag_x_high,
                 req_mag_y_low, req_mag_y_high};
            expected_angles.push_back(predict_angles(w));
         end
         if (rsp_valid) begin
            if (expected_angles.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_angles.pop_front();
               if (rsp_roll_degrees !== want.roll)
                  report_mismatch("roll", rsp_roll_degrees, want.roll);
               if (rsp_pitch_degrees !== want.pitch)
                  report_mismatch("pitch", rsp_pitch_degrees, want.pitch);
               if (rsp_heading_degrees !== want.heading)
                  report_mismatch("heading", rsp_heading_degrees, want.heading);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic sensor_word_type pack_word(logic [15:0] ax, logic [15:0] ay,
                                                 logic [15:0] az, logic [15:0] mx,
                                                 logic [15:0] my);
      return {ax, ay, az, mx[7:0], mx[15:8], my[7:0], my[15:8]};
   endfunction

   // Pick an axis value: mostly full range, with zeros, extremes and small values.
   function automatic logic [15:0] pick_axis();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
         2, 3: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || expected_angles.size() > 0 || start)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      if (idx == tac_pkg::CSR_MAG_ADJUST_X) adjust_x = val;
      else adjust_y = val;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_random(int count);
      repeat (count)
         pending_words.push_back(pack_word(pick_axis(), pick_axis(), pick_axis(),
                                           pick_axis(), pick_axis()));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset adjustment: zero vectors, zero
      // denominators, negative denominators and the axis extremes.
      pending_words.push_back(pack_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      pending_words.push_back(pack_word(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000));
      pending_words.push_back(pack_word(16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000));
      pending_words.push_back(pack_word(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000));
      pending_words.push_back(pack_word(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF));
      pending_words.push_back(pack_word(16'h0000, 16'h0000, 16'h7FFF, 16'h0001, 16'hFFFF));
      pending_words.push_back(pack_word(16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF));
      pending_words.push_back(pack_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      pending_words.push_back(pack_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      pending_words.push_back(pack_word(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'h0001));
      pending_words.push_back(pack_word(16'h00FF, 16'hFF00, 16'h5A5A, 16'hA5A5, 16'h00FF));
      pending_words.push_back(pack_word(16'h0001, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
      run_random(200);
      wait_drained();

      // Sweep the adjustment bytes through the extremes and random values.
      write_reg(tac_pkg::CSR_MAG_ADJUST_X, 8'd0);
      write_reg(tac_pkg::CSR_MAG_ADJUST_Y, 8'd255);
      run_random(200);
      wait_drained();
      write_reg(tac_pkg::CSR_MAG_ADJUST_X, 8'd255);
      write_reg(tac_pkg::CSR_MAG_ADJUST_Y, 8'd0);
      run_random(200);
      wait_drained();
      write_reg(tac_pkg::CSR_MAG_ADJUST_X, 8'd0);
      write_reg(tac_pkg::CSR_MAG_ADJUST_Y, 8'd0);
      run_random(150);
      wait_drained();
      write_reg(tac_pkg::CSR_MAG_ADJUST_X, 8'($urandom));
      write_reg(tac_pkg::CSR_MAG_ADJUST_Y, 8'($urandom));
      run_random(200);
      wait_drained();

      // Last part: back-to-back words, no idling.
      write_reg(tac_pkg::CSR_MAG_ADJUST_X, 8'd255);
      write_reg(tac_pkg::CSR_MAG_ADJUST_Y, 8'd255);
      quiet_tail = 1'b1;
      idle_left  = 0;
      run_random(150);
      wait_drained();

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
